### hw/rtl/akf_pkg.sv
// shared types, constants and helpers for the altitude kalman filter
package akf_pkg;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 20;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_VAR  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEAS_NOISE = 1'd1;

    // configuration reset values
    localparam logic [15:0] ACCEL_VAR_RESET  = 16'd50;
    localparam logic [19:0] MEAS_NOISE_RESET = 20'd900;

    // covariance diagonal after reset, 1000 cm^2 in q32.16
    localparam logic signed [47:0] COV_DIAG_RESET = 48'sd65536000;

    // saturation bounds
    localparam logic signed [47:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SAT_MIN = 48'sh8000_0000_0000;

    // scaling modes of the multiply-divide unit
    localparam logic [2:0] MD_SH4  = 3'd0;
    localparam logic [2:0] MD_SH6  = 3'd1;
    localparam logic [2:0] MD_SH20 = 3'd2;
    localparam logic [2:0] MD_SH21 = 3'd3;
    localparam logic [2:0] MD_DIV  = 3'd4;

    typedef struct packed {
        logic signed [31:0] vertical_accel;
        logic signed [23:0] measured_altitude;
        logic        [23:0] step_time;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] altitude_estimate;
        logic signed [47:0] velocity_estimate;
    } out_item_t;

    // one request to the multiply-divide unit
    typedef struct packed {
        logic signed [48:0] op_a;
        logic signed [48:0] op_b;
        logic        [48:0] divisor;
        logic        [2:0]  mode;
    } md_req_t;

    // sign extend a 48 bit value to 51 bits
    function automatic logic signed [50:0] ext51(input logic signed [47:0] x);
        return $signed({{3{x[47]}}, x});
    endfunction

    // clamp a 51 bit sum to the 48 bit signed range
    function automatic logic signed [47:0] sat48(input logic signed [50:0] x);
        logic signed [47:0] r;
        if ((x[50:47] == 4'b0000) || (x[50:47] == 4'b1111)) begin
            r = x[47:0];
        end else if (x[50]) begin
            r = SAT_MIN;
        end else begin
            r = SAT_MAX;
        end
        return r;
    endfunction

endpackage

### hw/rtl/altitude_kalman_filter.sv
// top level of the two-state altitude and velocity kalman filter
// all arithmetic runs one step at a time through one shared bit-serial
// multiply-divide unit: every step multiplies, and each gain term then divides;
// the correction is skipped when the innovation variance is not positive
// one item at a time, though a new input is taken while a result waits
// reset: synchronous active low, clears state, restores config and covariance
module altitude_kalman_filter import akf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // sequencer steps
    localparam logic [3:0] OP_DT2    = 4'd0;
    localparam logic [3:0] OP_DT4    = 4'd1;
    localparam logic [3:0] OP_ALT_V  = 4'd2;
    localparam logic [3:0] OP_ALT_A  = 4'd3;
    localparam logic [3:0] OP_VEL_A  = 4'd4;
    localparam logic [3:0] OP_QA     = 4'd5;
    localparam logic [3:0] OP_QV     = 4'd6;
    localparam logic [3:0] OP_P00_X  = 4'd7;
    localparam logic [3:0] OP_P00_D  = 4'd8;
    localparam logic [3:0] OP_PX_DT  = 4'd9;
    localparam logic [3:0] OP_C_ALT  = 4'd10;
    localparam logic [3:0] OP_C_VEL  = 4'd11;
    localparam logic [3:0] OP_C_P11  = 4'd12;
    localparam logic [3:0] OP_C_P01  = 4'd13;
    localparam logic [3:0] OP_C_P10  = 4'd14;
    localparam logic [3:0] OP_C_P00  = 4'd15;

    logic [2:0] state_reg;
    logic [3:0] step_reg;

    logic [15:0] var_reg;
    logic [19:0] r_reg;

    logic signed [31:0] acc_in_reg;
    logic signed [23:0] z_reg;
    logic        [23:0] dt_reg;

    logic signed [47:0] alt_reg, vel_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [47:0] dt2_reg, dt4_reg, qa_reg, qv_reg;
    logic signed [50:0] sum_reg;
    logic signed [48:0] y_reg;
    logic        [48:0] s_div_reg;

    logic               m_valid_reg;
    out_item_t          m_data_reg;

    md_req_t            md_req;
    logic               md_start;
    logic               md_done;
    logic signed [47:0] md_res;
    logic signed [50:0] res51;
    logic signed [50:0] s_sum;
    logic               s_pos;

    assign res51 = ext51(md_res);
    assign s_sum = ext51(p00_reg) + $signed({15'd0, r_reg, 16'd0});
    assign s_pos = !s_sum[50] && (s_sum != '0);

    // operand selection per step
    always_comb begin
        md_req.divisor = s_div_reg;
        md_req.mode    = MD_SH20;
        md_req.op_a    = {dt2_reg[47], dt2_reg};
        md_req.op_b    = {dt2_reg[47], dt2_reg};
        case (step_reg)
            OP_DT2: begin
                md_req.op_a = {25'd0, dt_reg};
                md_req.op_b = {25'd0, dt_reg};
            end
            OP_DT4: begin
                md_req.op_a = {dt2_reg[47], dt2_reg};
                md_req.op_b = {dt2_reg[47], dt2_reg};
            end
            OP_ALT_V: begin
                md_req.op_a = {vel_reg[47], vel_reg};
                md_req.op_b = {25'd0, dt_reg};
            end
            OP_ALT_A: begin
                md_req.op_a = {{17{acc_in_reg[31]}}, acc_in_reg};
                md_req.op_b = {dt2_reg[47], dt2_reg};
                md_req.mode = MD_SH21;
            end
            OP_VEL_A: begin
                md_req.op_a = {{17{acc_in_reg[31]}}, acc_in_reg};
                md_req.op_b = {25'd0, dt_reg};
            end
            OP_QA: begin
                md_req.op_a = {33'd0, var_reg};
                md_req.op_b = {dt4_reg[47], dt4_reg};
                md_req.mode = MD_SH6;
            end
            OP_QV: begin
                md_req.op_a = {33'd0, var_reg};
                md_req.op_b = {dt2_reg[47], dt2_reg};
                md_req.mode = MD_SH4;
            end
            OP_P00_X: begin
                md_req.op_a = {p01_reg[47], p01_reg} + {p10_reg[47], p10_reg};
                md_req.op_b = {25'd0, dt_reg};
            end
            OP_P00_D: begin
                md_req.op_a = {p11_reg[47], p11_reg};
                md_req.op_b = {dt2_reg[47], dt2_reg};
            end
            OP_PX_DT: begin
                md_req.op_a = {p11_reg[47], p11_reg};
                md_req.op_b = {25'd0, dt_reg};
            end
            OP_C_ALT: begin
                md_req.op_a = {p00_reg[47], p00_reg};
                md_req.op_b = y_reg;
                md_req.mode = MD_DIV;
            end
            OP_C_VEL: begin
                md_req.op_a = {p10_reg[47], p10_reg};
                md_req.op_b = y_reg;
                md_req.mode = MD_DIV;
            end
            OP_C_P11: begin
                md_req.op_a = {p10_reg[47], p10_reg};
                md_req.op_b = {p01_reg[47], p01_reg};
                md_req.mode = MD_DIV;
            end
            OP_C_P01: begin
                md_req.op_a = {p00_reg[47], p00_reg};
                md_req.op_b = {p01_reg[47], p01_reg};
                md_req.mode = MD_DIV;
            end
            OP_C_P10: begin
                md_req.op_a = {p10_reg[47], p10_reg};
                md_req.op_b = {p00_reg[47], p00_reg};
                md_req.mode = MD_DIV;
            end
            OP_C_P00: begin
                md_req.op_a = {p00_reg[47], p00_reg};
                md_req.op_b = {p00_reg[47], p00_reg};
                md_req.mode = MD_DIV;
            end
            default: begin
                md_req.mode = MD_SH20;
            end
        endcase
    end

    assign md_start = (state_reg == ST_ISSUE);

    akf_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .req     (md_req),
        .done    (md_done),
        .result  (md_res)
    );

    // sequencer and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= OP_DT2;
            var_reg     <= ACCEL_VAR_RESET;
            r_reg       <= MEAS_NOISE_RESET;
            alt_reg     <= '0;
            vel_reg     <= '0;
            p00_reg     <= COV_DIAG_RESET;
            p01_reg     <= '0;
            p10_reg     <= '0;
            p11_reg     <= COV_DIAG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_ACCEL_VAR:  var_reg <= cfg_wdata[15:0];
                    CFG_MEAS_NOISE: r_reg   <= cfg_wdata;
                    default:        r_reg   <= r_reg;
                endcase
            end

            // result transfer
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        acc_in_reg <= s_data.vertical_accel;
                        z_reg      <= s_data.measured_altitude;
                        dt_reg     <= s_data.step_time;
                        step_reg   <= OP_DT2;
                        state_reg  <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (md_done) begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= (step_reg == OP_PX_DT) ? ST_CHECK :
                                     (step_reg == OP_C_P00) ? ST_OUT : ST_ISSUE;
                        case (step_reg)
                            OP_DT2:   dt2_reg <= md_res;
                            OP_DT4:   dt4_reg <= md_res;
                            OP_ALT_V: sum_reg <= ext51(alt_reg) + res51;
                            OP_ALT_A: alt_reg <= sat48(sum_reg + res51);
                            OP_VEL_A: vel_reg <= sat48(ext51(vel_reg) + res51);
                            OP_QA:    qa_reg  <= md_res;
                            OP_QV:    qv_reg  <= md_res;
                            OP_P00_X: sum_reg <= ext51(p00_reg) + res51;
                            OP_P00_D: p00_reg <= sat48(sum_reg + res51 + ext51(qa_reg));
                            OP_PX_DT: begin
                                p01_reg   <= sat48(ext51(p01_reg) + res51);
                                p10_reg   <= sat48(ext51(p10_reg) + res51);
                                p11_reg   <= sat48(ext51(p11_reg) + ext51(qv_reg));
                            end
                            OP_C_ALT: alt_reg <= sat48(ext51(alt_reg) + res51);
                            OP_C_VEL: vel_reg <= sat48(ext51(vel_reg) + res51);
                            OP_C_P11: p11_reg <= sat48(ext51(p11_reg) - res51);
                            OP_C_P01: p01_reg <= sat48(ext51(p01_reg) - res51);
                            OP_C_P10: p10_reg <= sat48(ext51(p10_reg) - res51);
                            OP_C_P00: begin
                                p00_reg   <= sat48(ext51(p00_reg) - res51);
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CHECK: begin
                    // innovation and its variance; skip correction if not positive
                    s_div_reg <= s_sum[48:0];
                    y_reg     <= $signed({{9{z_reg[23]}}, z_reg, 16'd0})
                                 - {alt_reg[47], alt_reg};
                    state_reg <= s_pos ? ST_ISSUE : ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.altitude_estimate <= alt_reg;
                        m_data_reg.velocity_estimate <= vel_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hw/rtl/akf_muldiv.sv
// bit-serial round(a*b/d) unit with 48 bit saturation
module akf_muldiv import akf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  md_req_t            req,
    output logic               done,
    output logic signed [47:0] result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SHF  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [6:0] MUL_LAST = 7'd48;
    localparam logic [6:0] DIV_LAST = 7'd97;

    logic [2:0]  state_reg;
    logic [6:0]  cnt_reg;
    logic [48:0] ma_reg, mb_reg, hi_reg, lo_reg, d_reg, rem_reg;
    logic [47:0] q_reg;
    logic [2:0]  mode_reg;
    logic        neg_reg, ovf_reg, rnd_reg, done_reg;
    logic signed [47:0] res_reg;

    logic [49:0] add_sum;
    logic [49:0] rem_sh;
    logic        rem_ge;
    logic [97:0] prod;
    logic [97:0] shifted;
    logic        shf_rnd;
    logic        fin_rnd;
    logic [48:0] q_rnd;
    logic [48:0] limit;
    logic [48:0] mag;

    assign prod = {hi_reg, lo_reg};

    // one shift-add step of the multiply
    assign add_sum = {1'b0, hi_reg} + (mb_reg[0] ? {1'b0, ma_reg} : 50'd0);

    // one restoring step of the divide
    assign rem_sh = {rem_reg, hi_reg[48]};
    assign rem_ge = rem_sh >= {1'b0, d_reg};

    // power of two scaling
    always_comb begin
        case (mode_reg)
            MD_SH4: begin
                shifted = prod >> 4;
                shf_rnd = prod[3];
            end
            MD_SH6: begin
                shifted = prod >> 6;
                shf_rnd = prod[5];
            end
            MD_SH20: begin
                shifted = prod >> 20;
                shf_rnd = prod[19];
            end
            MD_SH21: begin
                shifted = prod >> 21;
                shf_rnd = prod[20];
            end
            default: begin
                shifted = prod;
                shf_rnd = 1'b0;
            end
        endcase
    end

    // rounding and saturation
    always_comb begin
        fin_rnd = (mode_reg == MD_DIV) ? ({rem_reg, 1'b0} >= {1'b0, d_reg}) : rnd_reg;
        q_rnd   = {1'b0, q_reg} + {48'd0, fin_rnd};
        limit   = neg_reg ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;
        mag     = (ovf_reg || (q_rnd > limit)) ? limit : q_rnd;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == ST_FIN);
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (cnt_reg == MUL_LAST) begin
                        state_reg <= (mode_reg == MD_DIV) ? ST_DIV : ST_SHF;
                    end
                end
                ST_SHF: begin
                    state_reg <= ST_FIN;
                end
                ST_DIV: begin
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                neg_reg  <= req.op_a[48] ^ req.op_b[48];
                ma_reg   <= req.op_a[48] ? 49'(-req.op_a) : req.op_a;
                mb_reg   <= req.op_b[48] ? 49'(-req.op_b) : req.op_b;
                d_reg    <= req.divisor;
                mode_reg <= req.mode;
                hi_reg   <= '0;
                lo_reg   <= '0;
                cnt_reg  <= '0;
            end
            ST_MUL: begin
                hi_reg  <= add_sum[49:1];
                lo_reg  <= {add_sum[0], lo_reg[48:1]};
                mb_reg  <= {1'b0, mb_reg[48:1]};
                cnt_reg <= (cnt_reg == MUL_LAST) ? 7'd0 : cnt_reg + 7'd1;
                rem_reg <= '0;
                q_reg   <= '0;
                ovf_reg <= 1'b0;
            end
            ST_SHF: begin
                q_reg   <= shifted[47:0];
                ovf_reg <= |shifted[97:48];
                rnd_reg <= shf_rnd;
            end
            ST_DIV: begin
                {hi_reg, lo_reg} <= {hi_reg[47:0], lo_reg, 1'b0};
                rem_reg <= rem_ge ? 49'(rem_sh - {1'b0, d_reg}) : rem_sh[48:0];
                q_reg   <= {q_reg[46:0], rem_ge};
                ovf_reg <= ovf_reg | q_reg[47];
                cnt_reg <= cnt_reg + 7'd1;
            end
            ST_FIN: begin
                res_reg <= neg_reg ? 48'(-mag) : mag[47:0];
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### hw/rtl/akf_checker.sv
// port-level checks for the altitude kalman filter, bound to the top level
module akf_checker import akf_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a held result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // a held result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed before transfer");

    // an input transfer starts work, so no second input next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // no result is offered right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered out of reset");

    // a result never appears in the cycle right after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result without computation");

endmodule

bind altitude_kalman_filter akf_checker u_akf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/tb_altitude_kalman_filter.sv
// self-checking testbench for the altitude kalman filter: directed table, then random tracking
module tb_altitude_kalman_filter;
    import akf_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES   = 3000;
    localparam int unsigned HOLD_OFF       = 4000;
    localparam int unsigned RANDOM_PER_SET = 306;
    localparam longint     Q48_MAX         = 64'sd140737488355327;
    localparam longint     Q48_MIN         = -64'sd140737488355328;

    typedef struct {
        logic signed [31:0] accel;
        logic signed [23:0] alt_cm;
        logic        [23:0] dt;
        bit                 known;
        logic signed [47:0] exp_alt;
        logic signed [47:0] exp_vel;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // filter state mirrored by the predictor
    longint unsigned var_cfg, rnoise_cfg;
    longint est_alt, est_vel;
    longint cov [4];

    out_item_t estimate_q [$];
    int unsigned n_errors = 0, n_sent = 0, n_checked = 0, n_skipped = 0, n_saturated = 0;
    bit  idle_enable = 1'b1;
    bit  hold_request = 1'b0;
    int unsigned quiet_cycles = 0;

    altitude_kalman_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // round(a*b/d) to nearest, ties away from zero, clamped to 48 bits
    function automatic longint round_mul_div(longint a, longint b, longint unsigned d);
        logic         neg;
        logic [63:0]  ma, mb, lim;
        logic [127:0] prod, quo, rem;
        neg  = (a < 0) != (b < 0);
        ma   = a;
        mb   = b;
        if (a < 0) ma = -ma;
        if (b < 0) mb = -mb;
        prod = {64'd0, ma} * {64'd0, mb};
        quo  = prod / {64'd0, d};
        rem  = prod % {64'd0, d};
        if (rem >= {64'd0, d} - rem) quo = quo + 1;
        lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 1);
        if (quo > {64'd0, lim}) quo = {64'd0, lim};
        return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function automatic longint clamp48(longint x);
        if (x > Q48_MAX) return Q48_MAX;
        if (x < Q48_MIN) return Q48_MIN;
        return x;
    endfunction

    // one predict step and, when the innovation variance is positive, one correct step of the filter
    function automatic out_item_t filter_step(in_item_t it);
        longint a, z, dt, dt2, dt4, qa, qv, alt, vel, n00, n01, n10, n11, s, y;
        out_item_t r;
        a   = longint'(it.vertical_accel);
        z   = longint'(it.measured_altitude);
        dt  = longint'(it.step_time);
        dt2 = round_mul_div(dt, dt, 64'd1 << 20);
        dt4 = round_mul_div(dt2, dt2, 64'd1 << 20);
        alt = clamp48(est_alt + round_mul_div(est_vel, dt, 64'd1 << 20)
                      + round_mul_div(a, dt2, 64'd1 << 21));
        vel = clamp48(est_vel + round_mul_div(a, dt, 64'd1 << 20));
        qa  = round_mul_div(longint'(var_cfg), dt4, 64'd1 << 6);
        qv  = round_mul_div(longint'(var_cfg), dt2, 64'd1 << 4);
        n00 = clamp48(cov[0] + round_mul_div(cov[1] + cov[2], dt, 64'd1 << 20)
                      + round_mul_div(cov[3], dt2, 64'd1 << 20) + qa);
        n01 = clamp48(cov[1] + round_mul_div(cov[3], dt, 64'd1 << 20));
        n10 = clamp48(cov[2] + round_mul_div(cov[3], dt, 64'd1 << 20));
        n11 = clamp48(cov[3] + qv);
        s   = n00 + longint'(rnoise_cfg) * 65536;
        if (s > 0) begin
            y   = z * 65536 - alt;
            alt = clamp48(alt + round_mul_div(n00, y, s));
            vel = clamp48(vel + round_mul_div(n10, y, s));
            cov[0] = clamp48(n00 - round_mul_div(n00, n00, s));
            cov[1] = clamp48(n01 - round_mul_div(n00, n01, s));
            cov[2] = clamp48(n10 - round_mul_div(n10, n00, s));
            cov[3] = clamp48(n11 - round_mul_div(n10, n01, s));
        end else begin
            n_skipped++;
            cov[0] = n00; cov[1] = n01; cov[2] = n10; cov[3] = n11;
        end
        est_alt = alt;
        est_vel = vel;
        if (alt == Q48_MAX || alt == Q48_MIN || vel == Q48_MAX || vel == Q48_MIN)
            n_saturated++;
        r.altitude_estimate = alt[47:0];
        r.velocity_estimate = vel[47:0];
        return r;
    endfunction

    // watchdog on the cycles since the last transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d estimates pending",
                         $time, estimate_q.size());
                $display("tb_altitude_kalman_filter: done, errors");
                $finish;
            end
        end
    end

    // result check against the oldest pending estimate
    always @(posedge aclk) begin
        out_item_t want;
        if (m_valid && m_ready) begin
            if (estimate_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result alt=%0d vel=%0d", $time,
                         m_data.altitude_estimate, m_data.velocity_estimate);
            end else begin
                want = estimate_q.pop_front();
                n_checked++;
                if (m_data.altitude_estimate !== want.altitude_estimate) begin
                    n_errors++;
                    $display("%0t: altitude expected %0d got %0d", $time,
                             want.altitude_estimate, m_data.altitude_estimate);
                end
                if (m_data.velocity_estimate !== want.velocity_estimate) begin
                    n_errors++;
                    $display("%0t: velocity expected %0d got %0d", $time,
                             want.velocity_estimate, m_data.velocity_estimate);
                end
            end
        end
    end

    // result side backpressure, with one long hold-off on request
    initial begin
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = idle_enable ? $urandom_range(0, 4) : 0;
            if (hold_request) begin
                stall = HOLD_OFF;
                hold_request = 1'b0;
            end
            m_ready = 1'b0;
            repeat (stall) @(negedge aclk);
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        if (idx == CFG_ACCEL_VAR) var_cfg = 64'(val[15:0]);
        else if (idx == CFG_MEAS_NOISE) rnoise_cfg = 64'(val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // block must be idle before a register write
    task automatic wait_drained();
        while (estimate_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // offer one measurement, predict on transfer
    task automatic send_measurement(in_item_t it, bit known, out_item_t typed);
        int unsigned gap;
        out_item_t pred;
        gap = idle_enable ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = filter_step(it);
        estimate_q.push_back(known ? typed : pred);
        n_sent++;
        @(negedge aclk);
    endtask

    // random measurement: mostly a plausible flight, some raw noise and edge values
    task automatic send_random(inout int track_cm);
        in_item_t it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            track_cm = track_cm + int'($urandom_range(0, 400)) - 200;
            if (track_cm > 8000000 || track_cm < -8000000) track_cm = 0;
            it.vertical_accel    = (int'($urandom_range(0, 4000)) - 2000) * 65536
                                   + int'($urandom_range(0, 65535));
            it.measured_altitude = 24'(track_cm + int'($urandom_range(0, 60)) - 30);
            it.step_time         = 24'($urandom_range(10000, 60000));
        end else if (pick < 90) begin
            it.vertical_accel    = $urandom();
            it.measured_altitude = 24'($urandom());
            it.step_time         = 24'($urandom());
        end else if (pick < 95) begin
            it.vertical_accel    = $urandom();
            it.measured_altitude = 24'($urandom());
            it.step_time         = '0;
        end else begin
            it.vertical_accel    = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            it.measured_altitude = $urandom_range(0, 1) ? 24'sh7F_FFFF : 24'sh80_0000;
            it.step_time         = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd1;
        end
        send_measurement(it, 1'b0, '0);
    endtask

    initial begin
        stim_row_t rows [$];
        in_item_t  it;
        out_item_t typed;
        int        track_cm;
        int unsigned set_i, k;
        logic [15:0] var_sets [5];
        logic [19:0] noise_sets [5];

        var_cfg = 64'(ACCEL_VAR_RESET);
        rnoise_cfg = 64'(MEAS_NOISE_RESET);
        est_alt = 0;
        est_vel = 0;
        cov[0] = 64'(COV_DIAG_RESET); cov[1] = 0; cov[2] = 0; cov[3] = 64'(COV_DIAG_RESET);

        // directed rows; only the first has an obvious answer
        rows = '{
            '{32'sd0, 24'sd0, 24'd0, 1'b1, 48'sd0, 48'sd0},
            '{32'sd0, 24'sd100, 24'd26214, 1'b0, 48'sd0, 48'sd0},
            '{32'sd64290816, 24'sd150, 24'd26214, 1'b0, 48'sd0, 48'sd0},
            '{-32'sd64290816, 24'sd120, 24'd26214, 1'b0, 48'sd0, 48'sd0},
            '{32'sd0, 24'sd0, 24'd0, 1'b0, 48'sd0, 48'sd0},
            '{32'sh7FFF_FFFF, 24'sh7F_FFFF, 24'd26214, 1'b0, 48'sd0, 48'sd0},
            '{32'sh8000_0000, 24'sh80_0000, 24'd26214, 1'b0, 48'sd0, 48'sd0},
            '{32'sd0, 24'sd0, 24'hFF_FFFF, 1'b0, 48'sd0, 48'sd0},
            '{32'sh7FFF_FFFF, 24'sh7F_FFFF, 24'hFF_FFFF, 1'b0, 48'sd0, 48'sd0},
            '{32'sh7FFF_FFFF, 24'sh7F_FFFF, 24'hFF_FFFF, 1'b0, 48'sd0, 48'sd0},
            '{32'sh8000_0000, 24'sh80_0000, 24'hFF_FFFF, 1'b0, 48'sd0, 48'sd0},
            '{32'sh8000_0000, 24'sh80_0000, 24'hFF_FFFF, 1'b0, 48'sd0, 48'sd0},
            '{32'sd0, 24'sd0, 24'd1, 1'b0, 48'sd0, 48'sd0},
            '{32'sd0, -24'sd5000, 24'd0, 1'b0, 48'sd0, 48'sd0},
            '{32'sd65536, 24'sd10, 24'd1048576, 1'b0, 48'sd0, 48'sd0},
            '{-32'sd1, -24'sd1, 24'd26214, 1'b0, 48'sd0, 48'sd0}
        };

        // register settings per phase: reset values, low extreme, high extreme,
        // zero noise, random
        var_sets   = '{ACCEL_VAR_RESET, 16'd0, 16'hFFFF, 16'd200, 16'd0};
        noise_sets = '{MEAS_NOISE_RESET, 20'd1, 20'hF_FFFF, 20'd0, 20'd0};
        var_sets[4]   = 16'($urandom());
        noise_sets[4] = 20'($urandom_range(1, 20'hF_FFFF));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            it.vertical_accel    = rows[i].accel;
            it.measured_altitude = rows[i].alt_cm;
            it.step_time         = rows[i].dt;
            typed.altitude_estimate = rows[i].exp_alt;
            typed.velocity_estimate = rows[i].exp_vel;
            send_measurement(it, rows[i].known, typed);
        end

        track_cm = 0;
        for (set_i = 0; set_i < 5; set_i++) begin
            s_valid = 1'b0;
            wait_drained();
            write_reg(CFG_ACCEL_VAR, {4'd0, var_sets[set_i]});
            write_reg(CFG_MEAS_NOISE, noise_sets[set_i]);
            for (k = 0; k < RANDOM_PER_SET; k++) begin
                // a stretch without idling, and one long result hold-off
                idle_enable = !(set_i == 1 && k >= 100 && k < 200);
                if (set_i == 2 && k == 50) hold_request = 1'b1;
                send_random(track_cm);
            end
        end
        s_valid = 1'b0;

        while (estimate_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d measurements sent, %0d estimates checked, %0d saturated",
                 n_sent, n_checked, n_saturated);
        $display("run: 5 register settings, %0d steps with correction skipped", n_skipped);
        if (n_errors == 0 && estimate_q.size() == 0) begin
            $display("tb_altitude_kalman_filter: done, clean");
        end else begin
            $display("tb_altitude_kalman_filter: done, errors");
        end
        $finish;
    end

endmodule
